// ===== sv/mte_pkg.sv =====
package mte_pkg;

	localparam int unsigned PT_W       = 7;
	localparam int unsigned SIZE_W     = 3;
	localparam int unsigned PC_W       = 3;
	localparam int unsigned MAX_POINTS = 7;
	localparam int unsigned APB_AW     = 3;
	localparam int unsigned APB_DW     = 32;

	// register byte addresses, index in bit 2
	localparam logic [APB_AW-1:0] ADDR_NPTS = 3'd0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic clear;
		logic acc;
	} hit_ctl_t;

	function automatic logic [SIZE_W-1:0] ones7(input logic [PT_W-1:0] v);
		logic [SIZE_W-1:0] n;
		n = '0;
		for (int i = 0; i < PT_W; i++) begin
			n = n + SIZE_W'(v[i]);
		end
		return n;
	endfunction

endpackage

// ===== sv/mte_edge_ram.sv =====
module mte_edge_ram import mte_pkg::*; #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  logic [PT_W-1:0] wr_data,
	input  logic [AW-1:0]   rd_addr,
	output logic [PT_W-1:0] rd_data
);

	logic [PT_W-1:0] mem_q [DEPTH];
	logic [PT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/mte_hit_unit.sv =====
module mte_hit_unit import mte_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  hit_ctl_t        ctl,
	input  logic [PT_W-1:0] set_mask,
	input  logic [PT_W-1:0] edge_bits,
	output logic            all_met,
	output logic [PT_W-1:0] private_pts
);

	logic            ok_q;
	logic [PT_W-1:0] priv_q;
	logic [PT_W-1:0] hit;
	logic            single;

	// an edge met by one point only makes that point indispensable
	assign hit    = set_mask & edge_bits;
	assign single = (hit != '0) && ((hit & (hit - PT_W'(1))) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q   <= 1'b1;
			priv_q <= '0;
		end else if (ctl.clear) begin
			ok_q   <= 1'b1;
			priv_q <= '0;
		end else if (ctl.acc) begin
			ok_q   <= ok_q & (hit != '0);
			priv_q <= priv_q | (single ? hit : '0);
		end
	end

	assign all_met     = ok_q;
	assign private_pts = priv_q;

endmodule

// ===== sv/minimal_transversal_enum_top.sv =====
// Minimal transversal enumerator: edges load into a row store, one item per cycle
// while edge_stall is low. A non-final edge item is taken without a stall; the final one
// starts a search that holds edge_stall high until the final result is taken into the
// output register, while the single edge compare unit walks every stored edge for each
// subset.
// Results leave through an output register; the search waits while it is full.
// arst_n (async, active low) empties the store, clears overflow, sets 7 points.
module minimal_transversal_enum_top import mte_pkg::*; #(
	parameter int unsigned MAX_EDGES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	// APB-style configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	// edge items in
	input  logic                edge_valid,
	output logic                edge_stall,
	input  logic [PT_W-1:0]     edge_mask,
	input  logic                last_edge,
	// result items out
	output logic                res_valid,
	input  logic                res_stall,
	output logic [PT_W-1:0]     transversal_mask,
	output logic [SIZE_W-1:0]   transversal_size,
	output logic                found,
	output logic                last_result,
	output logic                overflowed
);

	localparam int unsigned CNT_W = $clog2(MAX_EDGES + 1);
	localparam int unsigned AW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

	// ---------------------------------------------------------------------
	// Configuration
	// ---------------------------------------------------------------------
	logic [PC_W-1:0] pc_q;
	logic            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_NPTS[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_W'(MAX_POINTS);
		end else if (cfg_wr) begin
			pc_q <= pwdata[PC_W-1:0];
		end
	end

	assign prdata = (paddr[2] == ADDR_NPTS[2]) ? APB_DW'(pc_q) : '0;

	// effective point count is clamped; all_mask is the last subset searched
	logic [PC_W-1:0] pc_eff;
	logic [PT_W-1:0] all_mask;

	assign pc_eff   = (pc_q > PC_W'(MAX_POINTS)) ? PC_W'(MAX_POINTS) : pc_q;
	assign all_mask = ~({PT_W{1'b1}} << pc_eff);

	// ---------------------------------------------------------------------
	// Sequencer state and datapath registers
	// ---------------------------------------------------------------------
	state_t          state_q, state_d;
	logic [CNT_W-1:0] cnt_q;      // edges held in the store
	logic             ovf_q;      // sticky, edges dropped this set
	logic [PT_W-1:0]  set_q;      // candidate subset
	logic [CNT_W-1:0] k_q;        // edge read pointer
	logic             acc_s1;     // read data valid for the compare unit
	logic             pend_v_q;   // one minimal set held back so last_result is known
	logic [PT_W-1:0]  pend_q;

	logic             res_valid_q;
	logic [PT_W-1:0]  mask_q;
	logic [SIZE_W-1:0] size_q;
	logic             found_q;
	logic             last_q;
	logic             ovf_out_q;

	logic            edge_acc;
	logic            start;
	logic            store_room;
	logic            out_free;
	logic            scan_busy;
	logic            minimal;
	logic            eval_go;
	logic            emit_mid;
	logic            emit_fin;
	logic            issue;
	hit_ctl_t        hit_ctl;
	logic            all_met;
	logic [PT_W-1:0] private_pts;
	logic [PT_W-1:0] rd_edge;

	assign edge_stall = (state_q != ST_IDLE);
	assign edge_acc   = edge_valid && !edge_stall;
	assign start      = edge_acc && last_edge;
	assign store_room = (cnt_q < CNT_W'(MAX_EDGES));
	assign out_free   = !res_valid_q || !res_stall;
	assign scan_busy  = (k_q < cnt_q);
	// minimal: meets every edge and each point owns a private edge
	assign minimal    = all_met && (private_pts == set_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (all_mask == '0) ? ST_FLUSH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!scan_busy) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!(minimal && pend_v_q && !out_free)) begin
					state_d = (set_q == all_mask) ? ST_FLUSH : ST_SCAN;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		eval_go  = 1'b0;
		emit_fin = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			ST_IDLE:  ;
			ST_SCAN:  issue = scan_busy;
			ST_EVAL:  eval_go = !(minimal && pend_v_q && !out_free);
			ST_FLUSH: emit_fin = out_free;
			default:  ;
		endcase
		emit_mid      = eval_go && minimal && pend_v_q;
		hit_ctl.clear = start || eval_go;
		hit_ctl.acc   = acc_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			set_q    <= '0;
			k_q      <= '0;
			acc_s1   <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			acc_s1  <= issue;
			if (edge_acc) begin
				if (store_room) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (start) begin
				set_q <= PT_W'(1);
				k_q   <= '0;
			end else if (eval_go) begin
				set_q <= set_q + PT_W'(1);
				k_q   <= '0;
			end else if (issue) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (eval_go && minimal) begin
				pend_v_q <= 1'b1;
			end else if (emit_fin) begin
				pend_v_q <= 1'b0;
			end
			// store emptied once the set is finished
			if (emit_fin) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eval_go && minimal) begin
			pend_q <= set_q;
		end
	end

	// ---------------------------------------------------------------------
	// Edge store and compare unit
	// ---------------------------------------------------------------------
	mte_edge_ram #(
		.DEPTH (MAX_EDGES),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (edge_acc && store_room),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (edge_mask),
		.rd_addr (k_q[AW-1:0]),
		.rd_data (rd_edge)
	);

	mte_hit_unit u_hit (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (hit_ctl),
		.set_mask    (set_q),
		.edge_bits   (rd_edge),
		.all_met     (all_met),
		.private_pts (private_pts)
	);

	// ---------------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_mid || emit_fin) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_mid) begin
			mask_q    <= pend_q;
			size_q    <= ones7(pend_q);
			found_q   <= 1'b1;
			last_q    <= 1'b0;
			ovf_out_q <= ovf_q;
		end else if (emit_fin) begin
			// no minimal set at all gives the single not-found item
			mask_q    <= pend_v_q ? pend_q : '0;
			size_q    <= pend_v_q ? ones7(pend_q) : '0;
			found_q   <= pend_v_q;
			last_q    <= 1'b1;
			ovf_out_q <= ovf_q;
		end
	end

	assign res_valid        = res_valid_q;
	assign transversal_mask = mask_q;
	assign transversal_size = size_q;
	assign found            = found_q;
	assign last_result      = last_q;
	assign overflowed       = ovf_out_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_EDGES))
		else $error("edge count beyond store depth");

	a_priv_subset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_EVAL) |-> ((private_pts & ~set_q) == '0))
		else $error("private points outside candidate set");

	a_notfound_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !found) |-> (last_result && transversal_mask == '0))
		else $error("not-found item must be the only, final item");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fin |=> (cnt_q == '0 && !ovf_q && state_q == ST_IDLE))
		else $error("store not emptied after the final item");

endmodule
